// ----- sv/ttps_pkg.sv -----
// Shared types and constants of the transposition table probe store.
package ttps_pkg;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_PROBE  = 2'd1,
		REQ_CLEAR  = 2'd2
	} req_code_t;

	typedef enum logic [1:0] {
		BOUND_EXACT = 2'd0,
		BOUND_LOWER = 2'd1,
		BOUND_UPPER = 2'd2
	} bound_code_t;

	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MATE_IDX = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BAN_IDX  = 1'd1;

	localparam int unsigned CFG_DATA_W = 15;
	localparam logic [CFG_DATA_W-1:0] MATE_RESET = 15'd10000;
	localparam logic [CFG_DATA_W-1:0] BAN_RESET  = 15'd9900;

	typedef struct packed {
		logic               valid;
		logic [6:0]         depth;
		logic [31:0]        key_first;
		logic [31:0]        key_second;
		logic [15:0]        move;
		logic signed [15:0] score;
		logic [1:0]         bound;
	} entry_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [31:0]        key_index_part;
		logic [31:0]        key_check_part;
		logic [6:0]         search_depth;
		logic [15:0]        best_move;
		logic signed [15:0] score;
		logic [1:0]         bound_type;
		logic signed [15:0] alpha_bound;
		logic signed [15:0] beta_bound;
	} item_t;

	typedef struct packed {
		logic               wr;
		logic               hit;
		logic signed [15:0] score;
		logic [15:0]        move;
	} verdict_t;

endpackage

// ----- sv/ttps_if.sv -----
// Request and response channel interfaces.
interface ttps_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [31:0]        key_index_part;
	logic [31:0]        key_check_part;
	logic [6:0]         search_depth;
	logic [15:0]        best_move;
	logic signed [15:0] score;
	logic [1:0]         bound_type;
	logic signed [15:0] alpha_bound;
	logic signed [15:0] beta_bound;

	modport source (
		output valid, req_type, key_index_part, key_check_part, search_depth,
			best_move, score, bound_type, alpha_bound, beta_bound,
		input ready
	);
	modport sink (
		input valid, req_type, key_index_part, key_check_part, search_depth,
			best_move, score, bound_type, alpha_bound, beta_bound,
		output ready
	);
endinterface

interface ttps_rsp_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic signed [15:0] found_score;
	logic [15:0]        found_move;

	modport source (output valid, hit, found_score, found_move, input ready);
	modport sink (input valid, hit, found_score, found_move, output ready);
endinterface

// ----- sv/ttps_mem.sv -----
// Entry memory: one write port, one read port with registered read data.
module ttps_mem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  ttps_pkg::entry_t  wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output ttps_pkg::entry_t  rdata
);

	ttps_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/ttps_eval.sv -----
// Replace and hit decision for one request against the entry it selects.
module ttps_eval (
	input  ttps_pkg::item_t    item,
	input  ttps_pkg::entry_t   entry,
	input  logic [14:0]        mate_mag,
	input  logic [14:0]        ban_mag,
	output ttps_pkg::verdict_t verdict,
	output ttps_pkg::entry_t   wr_entry
);

	logic signed [16:0] neg_mate;
	logic signed [16:0] neg_ban;
	logic signed [16:0] new_score;
	logic signed [16:0] old_score;
	logic signed [16:0] st_score;
	logic [6:0]         old_depth;
	logic               deeper;
	logic               better;
	logic               key_ok;
	logic               bound_ok;

	always_comb begin
		neg_mate  = -$signed({2'b00, mate_mag});
		neg_ban   = -$signed({2'b00, ban_mag});
		new_score = 17'(item.score);
		st_score  = 17'(entry.score);
		// an empty entry counts as depth 0 with the mate floor as score
		old_depth = entry.valid ? entry.depth : 7'd0;
		old_score = entry.valid ? st_score : neg_mate;
		deeper    = item.search_depth > old_depth;
		better    = deeper || (item.search_depth == old_depth && new_score > old_score);

		key_ok = entry.valid && entry.key_first == item.key_index_part
			&& entry.key_second == item.key_check_part
			&& entry.depth >= item.search_depth;
		case (entry.bound)
			ttps_pkg::BOUND_EXACT: bound_ok = 1'b1;
			ttps_pkg::BOUND_LOWER: bound_ok = entry.score >= item.beta_bound;
			ttps_pkg::BOUND_UPPER: bound_ok = entry.score <= item.alpha_bound;
			default:               bound_ok = 1'b0;
		endcase

		verdict.wr    = item.req_type == ttps_pkg::REQ_INSERT && new_score > neg_ban && better;
		verdict.hit   = key_ok && bound_ok;
		verdict.score = verdict.hit ? entry.score : neg_mate[15:0];
		verdict.move  = verdict.hit ? entry.move : 16'd0;

		wr_entry.valid      = 1'b1;
		wr_entry.depth      = item.search_depth;
		wr_entry.key_first  = item.key_index_part;
		wr_entry.key_second = item.key_check_part;
		wr_entry.move       = item.best_move;
		wr_entry.score      = item.score;
		wr_entry.bound      = item.bound_type;
	end

endmodule

// ----- sv/transposition_table_probe_store_core.sv -----
// Transposition table probe store: top level with request control and sweep.
// Every request first does a synchronous read of the entry that the low index
// bits select, then compares and writes back through the single entry memory;
// no new request is taken until the last one is done. A probe result sits in
// an output register; the next request is taken while it waits, and only a
// following probe stalls until the word is taken. After reset and after each
// clear request the block walks the whole memory, one entry per cycle,
// clearing valid bits; no request is taken during that sweep, configuration
// writes are taken as always.
module transposition_table_probe_store_core #(
	parameter int unsigned TABLE_ENTRIES = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ttps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ttps_pkg::CFG_DATA_W-1:0]   cfg_data,
	ttps_req_if.sink                          req,
	ttps_rsp_if.source                        rsp
);

	localparam int unsigned AW = $clog2(TABLE_ENTRIES);
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

	logic [14:0]        mate_q;
	logic [14:0]        ban_q;
	logic               sweep_q;
	logic [AW-1:0]      sweep_cnt_q;
	logic               busy_s1;
	ttps_pkg::item_t    item_s1;
	logic               out_valid_q;
	logic               out_hit_q;
	logic signed [15:0] out_score_q;
	logic [15:0]        out_move_q;

	logic               accept;
	logic               is_probe;
	logic               done;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	ttps_pkg::entry_t   mem_wdata;
	ttps_pkg::entry_t   rd_entry;
	ttps_pkg::entry_t   wr_entry;
	ttps_pkg::verdict_t verdict;

	assign req.ready = !sweep_q && !busy_s1;
	assign accept    = req.valid && req.ready;
	assign is_probe  = item_s1.req_type == ttps_pkg::REQ_PROBE;
	// hold a probe while the previous result word is still waiting
	assign done      = busy_s1 && (!is_probe || !out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mate_q <= ttps_pkg::MATE_RESET;
			ban_q  <= ttps_pkg::BAN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ttps_pkg::CFG_MATE_IDX: mate_q <= cfg_data;
				ttps_pkg::CFG_BAN_IDX:  ban_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.req_type       <= req.req_type;
			item_s1.key_index_part <= req.key_index_part;
			item_s1.key_check_part <= req.key_check_part;
			item_s1.search_depth   <= req.search_depth;
			item_s1.best_move      <= req.best_move;
			item_s1.score          <= req.score;
			item_s1.bound_type     <= req.bound_type;
			item_s1.alpha_bound    <= req.alpha_bound;
			item_s1.beta_bound     <= req.beta_bound;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
		end else begin
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (done) begin
				busy_s1 <= 1'b0;
			end
			if (done && item_s1.req_type == ttps_pkg::REQ_CLEAR) begin
				sweep_q     <= 1'b1;
				sweep_cnt_q <= '0;
			end else if (sweep_q) begin
				sweep_cnt_q <= sweep_cnt_q + 1'b1;
				if (sweep_cnt_q == LAST_IDX) begin
					sweep_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		mem_we    = sweep_q || (busy_s1 && verdict.wr);
		mem_waddr = sweep_q ? sweep_cnt_q : item_s1.key_index_part[AW-1:0];
		mem_wdata = sweep_q ? '0 : wr_entry;
	end

	ttps_mem #(
		.DEPTH (TABLE_ENTRIES),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (req.key_index_part[AW-1:0]),
		.rdata (rd_entry)
	);

	ttps_eval u_eval (
		.item     (item_s1),
		.entry    (rd_entry),
		.mate_mag (mate_q),
		.ban_mag  (ban_q),
		.verdict  (verdict),
		.wr_entry (wr_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done && is_probe) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && is_probe) begin
			out_hit_q   <= verdict.hit;
			out_score_q <= verdict.score;
			out_move_q  <= verdict.move;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.found_score = out_score_q;
	assign rsp.found_move  = out_move_q;

	// memory writes come only from the sweep or a request in its compare and write-back step
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (sweep_q || busy_s1))
		else $error("entry write outside sweep or request");

	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(sweep_q && sweep_cnt_q == LAST_IDX && !(done && item_s1.req_type == ttps_pkg::REQ_CLEAR))
			|=> !sweep_q)
		else $error("sweep did not end after last entry");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_s1 && !req.ready))
		else $error("request not held after accept");

	a_probe_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_s1 && is_probe && out_valid_q && !rsp.ready) |=> (busy_s1 && out_valid_q))
		else $error("pending result word overwritten");

endmodule

// ----- bench/ttps_answer_check.sv -----
`timescale 1ns / 100ps
// Table predictor for the transposition table: tracks entries, checks every probe answer word.
module ttps_answer_check #(
	parameter int unsigned TABLE_ENTRIES = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ttps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ttps_pkg::CFG_DATA_W-1:0] cfg_data,
	ttps_req_if                             req,
	ttps_rsp_if                             rsp,
	output int unsigned                     fails,
	output int unsigned                     pending
);
	localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

	typedef struct packed {
		logic               hit;
		logic signed [15:0] score;
		logic [15:0]        move;
	} answer_t;

	ttps_pkg::entry_t                slot [TABLE_ENTRIES];
	logic [ttps_pkg::CFG_DATA_W-1:0] mate_mag;
	logic [ttps_pkg::CFG_DATA_W-1:0] ban_mag;
	answer_t                         answers [$];

	always @(posedge clk) begin : watch
		logic [IDX_W-1:0] idx;
		logic [6:0]       old_depth;
		int               sc;
		int               old_score;
		int               neg_mate;
		int               s;
		logic             usable;
		answer_t          want;
		answer_t          got;

		if (!arst_n) begin
			mate_mag = ttps_pkg::MATE_RESET;
			ban_mag = ttps_pkg::BAN_RESET;
			foreach (slot[i]) slot[i] = '0;
			answers.delete();
			fails = 0;
		end else begin
			// check the outgoing word before predicting, so a word that
			// overtakes its request shows up as unexpected
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.hit, rsp.found_score, rsp.found_move};
				if (answers.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: unexpected word hit %0d score %0d move 0x%04h",
							$time, got.hit, got.score, got.move);
				end else begin
					want = answers.pop_front();
					if (got.hit != want.hit || got.score != want.score ||
							got.move != want.move) begin
						fails++;
						if (fails <= 10)
							$display({"%0t: expected hit %0d score %0d move 0x%04h,",
								" got hit %0d score %0d move 0x%04h"},
								$time, want.hit, want.score, want.move,
								got.hit, got.score, got.move);
					end
				end
			end

			if (req.valid && req.ready) begin
				idx = req.key_index_part[IDX_W-1:0];
				sc = req.score;
				neg_mate = -int'(mate_mag);
				case (req.req_type)
				ttps_pkg::REQ_INSERT: begin
					if (sc > -int'(ban_mag)) begin
						// an empty slot competes as depth zero with a mate loss score
						if (slot[idx].valid) begin
							old_depth = slot[idx].depth;
							old_score = $signed(slot[idx].score);
						end else begin
							old_depth = 7'd0;
							old_score = neg_mate;
						end
						if (req.search_depth > old_depth ||
								(req.search_depth == old_depth && sc > old_score)) begin
							slot[idx].valid = 1'b1;
							slot[idx].depth = req.search_depth;
							slot[idx].key_first = req.key_index_part;
							slot[idx].key_second = req.key_check_part;
							slot[idx].move = req.best_move;
							slot[idx].score = req.score;
							slot[idx].bound = req.bound_type;
						end
					end
				end
				ttps_pkg::REQ_PROBE: begin
					want = '{1'b0, neg_mate[15:0], 16'd0};
					usable = 1'b0;
					if (slot[idx].valid && slot[idx].key_first == req.key_index_part &&
							slot[idx].key_second == req.key_check_part &&
							slot[idx].depth >= req.search_depth) begin
						s = $signed(slot[idx].score);
						case (slot[idx].bound)
						ttps_pkg::BOUND_EXACT: usable = 1'b1;
						ttps_pkg::BOUND_LOWER: usable = s >= int'(req.beta_bound);
						ttps_pkg::BOUND_UPPER: usable = s <= int'(req.alpha_bound);
						default: usable = 1'b0;
						endcase
					end
					if (usable)
						want = '{1'b1, slot[idx].score, slot[idx].move};
					answers.push_back(want);
				end
				ttps_pkg::REQ_CLEAR: begin
					foreach (slot[i]) slot[i].valid = 1'b0;
				end
				default: ;
				endcase
			end

			if (cfg_we) begin
				if (cfg_index == ttps_pkg::CFG_MATE_IDX)
					mate_mag = cfg_data;
				else if (cfg_index == ttps_pkg::CFG_BAN_IDX)
					ban_mag = cfg_data;
			end
		end
		pending = answers.size();
	end

endmodule

// ----- bench/transposition_table_probe_store_core_test.sv -----
`timescale 1ns / 100ps
// Stimulus and verdict for the transposition table probe store core.
module transposition_table_probe_store_core_test;

	localparam int unsigned TABLE_ENTRIES = 1024;
	localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
	localparam int unsigned POOL = 16;
	localparam int unsigned WORDS_PER_PHASE = 80;

	localparam logic [1:0] REQ_IGNORED = 2'd3;
	localparam logic [1:0] BOUND_NONE  = 2'd3;

	localparam logic [31:0] KEY_A = 32'h1234_5005;
	localparam logic [31:0] CHK_A = 32'h0BAD_F00D;
	localparam logic [31:0] KEY_B = 32'h0000_03FF;
	localparam logic [31:0] CHK_B = 32'hFFFF_FFFF;
	localparam logic [31:0] KEY_C = 32'h0000_0000;
	localparam logic [31:0] CHK_C = 32'h0000_0000;
	localparam logic [31:0] KEY_D = 32'hFFFF_FFFF;
	localparam logic [31:0] CHK_D = 32'hFFFF_FFFF;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [ttps_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ttps_pkg::CFG_DATA_W-1:0] cfg_data;
	int unsigned                     fails;
	int unsigned                     pending;
	bit                              calm;
	logic [ttps_pkg::CFG_DATA_W-1:0] ban_now;
	logic [31:0]                     pool_first [POOL];
	logic [31:0]                     pool_second [POOL];

	ttps_req_if req ();
	ttps_rsp_if rsp ();

	transposition_table_probe_store_core #(.TABLE_ENTRIES(TABLE_ENTRIES)) DUT (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .req(req), .rsp(rsp)
	);

	ttps_answer_check #(.TABLE_ENTRIES(TABLE_ENTRIES)) answer_check (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .req(req), .rsp(rsp),
		.fails, .pending
	);

	always #2 clk = ~clk;

	function automatic ttps_pkg::item_t make_word(logic [1:0] kind, logic [31:0] k1,
			logic [31:0] k2, logic [6:0] depth, logic [15:0] move, int sc,
			logic [1:0] bound, int alpha, int beta);
		ttps_pkg::item_t w;
		w.req_type = kind;
		w.key_index_part = k1;
		w.key_check_part = k2;
		w.search_depth = depth;
		w.best_move = move;
		w.score = 16'(sc);
		w.bound_type = bound;
		w.alpha_bound = 16'(alpha);
		w.beta_bound = 16'(beta);
		return w;
	endfunction

	// mostly keys from a small pool that crowds a few slots, so probes find entries
	function automatic ttps_pkg::item_t random_word();
		int unsigned r;
		int unsigned pick;
		logic [1:0]  kind;
		logic [1:0]  bound;
		logic [31:0] k1;
		logic [31:0] k2;
		logic [6:0]  depth;
		int          sc;
		int          alpha;
		int          beta;

		r = $urandom_range(0, 199);
		if (r < 92)
			kind = ttps_pkg::REQ_INSERT;
		else if (r < 192)
			kind = ttps_pkg::REQ_PROBE;
		else if (r < 197)
			kind = REQ_IGNORED;
		else
			kind = ttps_pkg::REQ_CLEAR;

		pick = $urandom_range(0, POOL - 1);
		if ($urandom_range(0, 9) != 0) begin
			k1 = pool_first[pick];
			k2 = pool_second[pick];
		end else begin
			k1 = $urandom;
			k2 = $urandom;
		end

		if ($urandom_range(0, 3) != 0)
			depth = 7'($urandom_range(0, 6));
		else
			depth = 7'($urandom_range(0, 127));

		r = $urandom_range(0, 9);
		if (r < 4)
			sc = int'($urandom_range(0, 600)) - 300;
		else if (r < 6)
			sc = int'($urandom_range(0, 4)) - 2 - int'(ban_now);
		else
			sc = int'($urandom_range(0, 65535)) - 32768;

		r = $urandom_range(0, 9);
		if (r < 3)
			bound = ttps_pkg::BOUND_EXACT;
		else if (r < 6)
			bound = ttps_pkg::BOUND_LOWER;
		else if (r < 9)
			bound = ttps_pkg::BOUND_UPPER;
		else
			bound = BOUND_NONE;

		if ($urandom_range(0, 2) != 0) begin
			alpha = int'($urandom_range(0, 600)) - 300;
			beta = int'($urandom_range(0, 600)) - 300;
		end else begin
			alpha = int'($urandom_range(0, 65535)) - 32768;
			beta = int'($urandom_range(0, 65535)) - 32768;
		end

		return make_word(kind, k1, k2, depth, 16'($urandom), sc, bound, alpha, beta);
	endfunction

	task automatic deal_keys();
		logic [IDX_W-1:0] home [6];
		foreach (home[i]) home[i] = IDX_W'($urandom);
		for (int i = 0; i < POOL; i++) begin
			// last few share a first key half with earlier ones, differ in the second
			if (i >= 12) begin
				pool_first[i] = pool_first[i - 12];
			end else begin
				pool_first[i] = $urandom;
				pool_first[i][IDX_W-1:0] = home[i % 6];
			end
			pool_second[i] = $urandom;
		end
	endtask

	task automatic send_word(input ttps_pkg::item_t w);
		@(negedge clk);
		req.valid <= 1'b1;
		req.req_type <= w.req_type;
		req.key_index_part <= w.key_index_part;
		req.key_check_part <= w.key_check_part;
		req.search_depth <= w.search_depth;
		req.best_move <= w.best_move;
		req.score <= w.score;
		req.bound_type <= w.bound_type;
		req.alpha_bound <= w.alpha_bound;
		req.beta_bound <= w.beta_bound;
		do @(posedge clk); while (!req.ready);
		if (!calm && $urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 15)) begin
				@(negedge clk);
				req.valid <= 1'b0;
			end
		end
	endtask

	task automatic write_reg(input logic [ttps_pkg::CFG_IDX_W-1:0] which,
			input logic [ttps_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold the request side until every answer is back and the last write has landed
	task automatic settle();
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		int unsigned hold;
		rsp.ready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				rsp.ready <= 1'b0;
				hold--;
			end else begin
				rsp.ready <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0)
					hold = $urandom_range(1, 15);
			end
		end
	end

	initial begin
		logic [ttps_pkg::CFG_DATA_W-1:0] mate_next;
		logic [ttps_pkg::CFG_DATA_W-1:0] ban_next;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.req_type = '0;
		req.key_index_part = '0;
		req.key_check_part = '0;
		req.search_depth = '0;
		req.best_move = '0;
		req.score = '0;
		req.bound_type = '0;
		req.alpha_bound = '0;
		req.beta_bound = '0;
		calm = 1'b0;
		ban_now = ttps_pkg::BAN_RESET;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table, then hits and misses on key halves, depth and bounds
		send_word(make_word(ttps_pkg::REQ_PROBE, KEY_A, CHK_A, 7'd0, 16'h0000, 0,
			ttps_pkg::BOUND_EXACT, 0, 0));
		send_word(make_word(ttps_pkg::REQ_INSERT, KEY_A, CHK_A, 7'd5, 16'h1234, 100,
			ttps_pkg::BOUND_EXACT, 0, 0));
		send_word(make_word(ttps_pkg::REQ_PROBE, KEY_A, CHK_A, 7'd5, 16'h0000, 0,
			ttps_pkg::BOUND_EXACT, 0, 0));
		send_word(make_word(ttps_pkg::REQ_PROBE, KEY_A, CHK_A, 7'd6, 16'h0000, 0,
			ttps_pkg::BOUND_EXACT, 0, 0));
		send_word(make_word(ttps_pkg::REQ_PROBE, KEY_A, ~CHK_A, 7'd0, 16'h0000, 0,
			ttps_pkg::BOUND_EXACT, 0, 0));
		send_word(make_word(ttps_pkg::REQ_PROBE, KEY_A ^ 32'h8000_0000, CHK_A, 7'd0,
			16'h0000, 0, ttps_pkg::BOUND_EXACT, 0, 0));
		// equal depth: lower score stays out, higher score replaces
		send_word(make_word(ttps_pkg::REQ_INSERT, KEY_A, CHK_A, 7'd5, 16'h5555, 50,
			ttps_pkg::BOUND_EXACT, 0, 0));
		send_word(make_word(ttps_pkg::REQ_INSERT, KEY_A, CHK_A, 7'd5, 16'hFFFF, 200,
			ttps_pkg::BOUND_LOWER, 0, 0));
		send_word(make_word(ttps_pkg::REQ_PROBE, KEY_A, CHK_A, 7'd0, 16'h0000, 0,
			ttps_pkg::BOUND_EXACT, 0, 200));
		send_word(make_word(ttps_pkg::REQ_PROBE, KEY_A, CHK_A, 7'd0, 16'h0000, 0,
			ttps_pkg::BOUND_EXACT, 0, 201));
		send_word(make_word(ttps_pkg::REQ_INSERT, KEY_A, CHK_A, 7'd3, 16'h0000, 9000,
			ttps_pkg::BOUND_EXACT, 0, 0));
		send_word(make_word(ttps_pkg::REQ_PROBE, KEY_A, CHK_A, 7'd5, 16'h0000, 0,
			ttps_pkg::BOUND_EXACT, 32767, -32768));
		// just above the ban line, upper bound against alpha
		send_word(make_word(ttps_pkg::REQ_INSERT, KEY_B, CHK_B, 7'd127, 16'hA5A5, -9899,
			ttps_pkg::BOUND_UPPER, 0, 0));
		send_word(make_word(ttps_pkg::REQ_PROBE, KEY_B, CHK_B, 7'd127, 16'h0000, 0,
			ttps_pkg::BOUND_EXACT, -9899, 0));
		send_word(make_word(ttps_pkg::REQ_PROBE, KEY_B, CHK_B, 7'd127, 16'h0000, 0,
			ttps_pkg::BOUND_EXACT, -9900, 0));
		// on the ban line nothing is stored; above it an empty slot takes it
		send_word(make_word(ttps_pkg::REQ_INSERT, KEY_C, CHK_C, 7'd0, 16'h0001, -9900,
			ttps_pkg::BOUND_EXACT, 0, 0));
		send_word(make_word(ttps_pkg::REQ_PROBE, KEY_C, CHK_C, 7'd0, 16'h0000, 0,
			ttps_pkg::BOUND_EXACT, 0, 0));
		send_word(make_word(ttps_pkg::REQ_INSERT, KEY_C, CHK_C, 7'd0, 16'h0001, -9899,
			ttps_pkg::BOUND_EXACT, 0, 0));
		send_word(make_word(ttps_pkg::REQ_PROBE, KEY_C, CHK_C, 7'd0, 16'h0000, 0,
			ttps_pkg::BOUND_EXACT, 0, 0));
		// undefined bound code is stored but never usable
		send_word(make_word(ttps_pkg::REQ_INSERT, KEY_D, CHK_D, 7'd127, 16'hFFFF, 32767,
			BOUND_NONE, 0, 0));
		send_word(make_word(ttps_pkg::REQ_PROBE, KEY_D, CHK_D, 7'd0, 16'h0000, 0,
			ttps_pkg::BOUND_EXACT, 32767, -32768));
		send_word(make_word(ttps_pkg::REQ_INSERT, KEY_D, CHK_D, 7'd0, 16'h0000, -32768,
			ttps_pkg::BOUND_EXACT, 0, 0));
		send_word(make_word(REQ_IGNORED, KEY_A, CHK_A, 7'd127, 16'hFFFF, 32767,
			ttps_pkg::BOUND_EXACT, 0, 0));
		send_word(make_word(ttps_pkg::REQ_PROBE, KEY_A, CHK_A, 7'd0, 16'h0000, 0,
			ttps_pkg::BOUND_EXACT, 0, -32768));
		send_word(make_word(ttps_pkg::REQ_CLEAR, KEY_A, CHK_A, 7'd0, 16'h0000, 0,
			ttps_pkg::BOUND_EXACT, 0, 0));
		send_word(make_word(ttps_pkg::REQ_PROBE, KEY_A, CHK_A, 7'd0, 16'h0000, 0,
			ttps_pkg::BOUND_EXACT, 0, -32768));

		for (int phase = 0; phase < 5; phase++) begin
			if (phase > 0) begin
				settle();
				case (phase)
				1: begin
					mate_next = 15'd32767;
					ban_next = 15'd0;
				end
				2: begin
					mate_next = 15'd0;
					ban_next = 15'd32767;
				end
				3: begin
					mate_next = 15'($urandom);
					ban_next = 15'($urandom);
				end
				default: begin
					mate_next = ttps_pkg::MATE_RESET;
					ban_next = ttps_pkg::BAN_RESET;
				end
				endcase
				write_reg(ttps_pkg::CFG_MATE_IDX, mate_next);
				write_reg(ttps_pkg::CFG_BAN_IDX, ban_next);
				ban_now = ban_next;
			end
			calm = (phase == 4);
			deal_keys();
			repeat (WORDS_PER_PHASE) send_word(random_word());
		end

		settle();
		if (fails == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
